### design/gop_aligned_prerecord_queue_assert.svh
// Assertion macros shared by the GOP-aligned prerecord queue modules.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef GOP_ALIGNED_PRERECORD_QUEUE_ASSERT_SVH
`define GOP_ALIGNED_PRERECORD_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define GAPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset
`define GAPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GAPQ_ASSERT_IMP(label, ante, cons, msg)
`define GAPQ_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

### design/gapq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and field layout for the GOP-aligned prerecord queue.
// No dependencies.
package gapq_pkg;

    // Default parameter values
    localparam int DEF_MAX_FRAMES = 256;
    localparam int DEF_LEN_BITS   = 24;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int FLEN_W     = 24;
    localparam int TIME_W     = 63;
    localparam int STATUS_W   = 3;
    localparam int OCNT_W     = 9;
    localparam int BYTES_W    = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // Input transaction layout
    localparam int IN_DATA_W    = 152;
    localparam int IN_LEN_LO    = 0;
    localparam int IN_FTIME_LO  = 24;
    localparam int IN_NOW_LO    = 87;
    localparam int IN_EVICT_BIT = 150;
    localparam int IN_USER_W      = 4;
    localparam int USER_CMD_LO    = 0;
    localparam int USER_KEY_BIT   = 2;
    localparam int USER_AUDIO_BIT = 3;

    // Output transaction layout
    localparam int OUT_DATA_W     = 144;
    localparam int OUT_STATUS_LO  = 0;
    localparam int OUT_HVALID_BIT = 3;
    localparam int OUT_HLEN_LO    = 4;
    localparam int OUT_HTIME_LO   = 28;
    localparam int OUT_HKEY_BIT   = 91;
    localparam int OUT_COUNT_LO   = 92;
    localparam int OUT_BYTES_LO   = 101;
    localparam int OUT_EVICT_LO   = 133;

    // Register indexes and reset values
    localparam logic [CFG_ADDR_W-1:0] REG_RECORD_ENABLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_BYTES     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPAN_US   = 2'd2;
    localparam int US_PER_SECOND = 1000000;
    localparam logic [BYTES_W-1:0] RST_MAX_BYTES   = 32'd16777216;
    localparam logic [BYTES_W-1:0] RST_MAX_SPAN_US = 32'(13 * US_PER_SECOND);

    // Commands
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DISABLED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_KEY  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd4;

    // Datapath queue operations
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_DROP  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic [1:0]          op;
        logic                evict_clr;
        logic                evict_inc;
        logic                load_later;
        logic                load_out;
        logic [STATUS_W-1:0] status;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic record_enable;
        logic count_zero;
        logic ring_full;
        logic head_vkey;
        logic evict_hit;
    } dp_stat_t;

endpackage

### design/gapq_datapath.sv
`timescale 1ns / 1ps
// Descriptor ring, pointers, byte total, config registers and result register.
// Depends on gapq_pkg and gop_aligned_prerecord_queue_assert.svh.
`include "gop_aligned_prerecord_queue_assert.svh"
module gapq_datapath #(
    parameter int MAX_FRAMES = gapq_pkg::DEF_MAX_FRAMES,
    parameter int LEN_BITS   = gapq_pkg::DEF_LEN_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gapq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [gapq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [gapq_pkg::FLEN_W-1:0]         frame_length,
    input  logic [gapq_pkg::TIME_W-1:0]         frame_time,
    input  logic                                key_frame,
    input  logic                                is_audio,
    input  logic [gapq_pkg::TIME_W-1:0]         now_time,
    input  gapq_pkg::dp_cmd_t                   cmd,
    output gapq_pkg::dp_stat_t                  stat,
    output logic [gapq_pkg::OUT_DATA_W-1:0]     out_data
);
    import gapq_pkg::*;

    localparam int PTR_W  = (MAX_FRAMES > 2) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int DESC_W = LEN_BITS + TIME_W + 2;
    localparam int T_LO   = LEN_BITS;
    localparam int K_BIT  = LEN_BITS + TIME_W;
    localparam int V_BIT  = K_BIT + 1;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_W'(MAX_FRAMES - 1)) ? '0 : p + 1'b1;
    endfunction

    // Descriptor memory: {video, key, time, length}
    logic [DESC_W-1:0] desc_mem [MAX_FRAMES];
    logic [DESC_W-1:0] head_desc_reg;
    logic [DESC_W-1:0] wr_data;
    logic              wr_en;

    logic [PTR_W-1:0]   head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BYTES_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0]   evict_cnt_reg;
    logic [TIME_W-1:0]  later_reg;
    logic               record_enable_reg;
    logic [BYTES_W-1:0] max_bytes_reg, max_span_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_word;

    logic [LEN_BITS-1:0] wr_len;
    logic [BYTES_W-1:0]  head_len32;
    logic [BYTES_W:0]    sum;
    logic [TIME_W:0]     span_diff;
    logic                span_hit;
    logic                last_entry;

    assign wr_len  = LEN_BITS'({8'd0, frame_length});
    assign wr_data = {~is_audio, key_frame, frame_time, wr_len};
    assign head_len32 = 32'(head_desc_reg[LEN_BITS-1:0]);
    assign sum = {1'b0, total_reg} + 33'(wr_len);
    assign last_entry = (count_reg == CNT_W'(1));

    // Next queue state for the requested operation
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        total_next = total_reg;
        wr_en      = 1'b0;
        case (cmd.op)
            OP_ADD:
            begin
                wr_en      = 1'b1;
                tail_next  = next_slot(tail_reg);
                count_next = count_reg + 1'b1;
                total_next = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
            end
            OP_DROP:
            begin
                if (last_entry)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                    total_next = '0;
                end
                else
                begin
                    head_next  = next_slot(head_reg);
                    count_next = count_reg - 1'b1;
                    total_next = (total_reg >= head_len32) ? total_reg - head_len32 : '0;
                end
            end
            OP_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
                total_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Queue control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            evict_cnt_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            total_reg <= total_next;
            if (cmd.evict_clr)
                evict_cnt_reg <= '0;
            else if (cmd.evict_inc)
                evict_cnt_reg <= evict_cnt_reg + 1'b1;
        end
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_enable_reg <= 1'b0;
            max_bytes_reg     <= RST_MAX_BYTES;
            max_span_reg      <= RST_MAX_SPAN_US;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_RECORD_ENABLE)
                record_enable_reg <= cfg_wdata[0];
            if (cfg_addr == REG_MAX_BYTES)
                max_bytes_reg <= cfg_wdata;
            if (cfg_addr == REG_MAX_SPAN_US)
                max_span_reg <= cfg_wdata;
        end
    end

    // Descriptor ring: write at tail, registered read of the next head
    always_ff @(posedge clk)
    begin
        if (wr_en)
            desc_mem[tail_reg] <= wr_data;
        if (wr_en && (tail_reg == head_next))
            head_desc_reg <= wr_data;
        else
            head_desc_reg <= desc_mem[head_next];
    end

    // Later of newest-frame time and now; eviction can drop the newest frame as well
    always_ff @(posedge clk)
    begin
        if (cmd.load_later)
            later_reg <= (frame_time > now_time) ? frame_time : now_time;
    end

    // Signed span check against the head timestamp
    assign span_diff = {1'b0, later_reg} - {1'b0, head_desc_reg[T_LO +: TIME_W]};
    assign span_hit  = !span_diff[TIME_W] &&
                       (span_diff[TIME_W-1:0] > TIME_W'(max_span_reg));

    assign stat.record_enable = record_enable_reg;
    assign stat.count_zero    = (count_reg == '0);
    assign stat.ring_full     = (count_reg == CNT_W'(MAX_FRAMES));
    assign stat.head_vkey     = head_desc_reg[K_BIT] & head_desc_reg[V_BIT];
    assign stat.evict_hit     = (total_reg > max_bytes_reg) || span_hit;

    // Result word
    always_comb
    begin
        out_word = '0;
        out_word[OUT_STATUS_LO +: STATUS_W] = cmd.status;
        out_word[OUT_COUNT_LO +: OCNT_W]    = OCNT_W'(32'(count_reg));
        out_word[OUT_BYTES_LO +: BYTES_W]   = total_reg;
        out_word[OUT_EVICT_LO +: OCNT_W]    = OCNT_W'(32'(evict_cnt_reg));
        if (count_reg != '0)
        begin
            out_word[OUT_HVALID_BIT]          = 1'b1;
            out_word[OUT_HLEN_LO +: FLEN_W]   = head_len32[FLEN_W-1:0];
            out_word[OUT_HTIME_LO +: TIME_W]  = head_desc_reg[T_LO +: TIME_W];
            out_word[OUT_HKEY_BIT]            = head_desc_reg[K_BIT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            out_data_reg <= out_word;
    end

    assign out_data = out_data_reg;

    `GAPQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_FRAMES),
        "frame count above ring depth")
    `GAPQ_ASSERT_IMP(a_empty_clean, count_reg == '0,
        (total_reg == '0) && (head_reg == tail_reg), "empty queue holds bytes or pointers")
    `GAPQ_ASSERT_IMP(a_no_add_full, cmd.op == OP_ADD, count_reg != CNT_W'(MAX_FRAMES),
        "add issued to a full ring")

endmodule

### design/gapq_ctrl.sv
`timescale 1ns / 1ps
// Controller: command decode, admission checks, eviction walk and result handoff.
// Depends on gapq_pkg and gop_aligned_prerecord_queue_assert.svh.
`include "gop_aligned_prerecord_queue_assert.svh"
module gapq_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [gapq_pkg::CMD_W-1:0]   command,
    input  logic                         key_frame,
    input  logic                         is_audio,
    input  logic                         allow_evict,
    input  gapq_pkg::dp_stat_t           stat,
    output gapq_pkg::dp_cmd_t            cmd
);
    import gapq_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EVICT  = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                in_group_reg, in_group_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                drop_ok;

    // Keep dropping inside a group; start a new group only while over the limit
    assign drop_ok = !stat.count_zero &&
                     ((in_group_reg && !stat.head_vkey) ||
                      ((!in_group_reg || stat.head_vkey) && stat.evict_hit));

    always_comb
    begin
        state_next    = state_reg;
        status_next   = status_reg;
        in_group_next = in_group_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        cmd           = '0;
        cmd.op        = OP_NONE;
        cmd.status    = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.evict_clr  = 1'b1;
                    cmd.load_later = 1'b1;
                    in_group_next  = 1'b0;
                    status_next    = STAT_OK;
                    state_next     = ST_RESULT;
                    case (command)
                        CMD_ADD:
                        begin
                            if (!stat.record_enable)
                                status_next = STAT_DISABLED;
                            else if (stat.count_zero && !(key_frame && !is_audio))
                                status_next = STAT_NOT_KEY;
                            else if (stat.ring_full)
                                status_next = STAT_FULL;
                            else
                            begin
                                cmd.op = OP_ADD;
                                if (allow_evict)
                                    state_next = ST_EVICT;
                            end
                        end
                        CMD_PEEK:
                        begin
                            if (stat.count_zero)
                                status_next = STAT_EMPTY;
                        end
                        CMD_POP:
                        begin
                            if (stat.count_zero)
                                status_next = STAT_EMPTY;
                            else
                                cmd.op = OP_DROP;
                        end
                        CMD_CLEAR:
                            cmd.op = OP_CLEAR;
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EVICT:
            begin
                if (drop_ok)
                begin
                    cmd.op        = OP_DROP;
                    cmd.evict_inc = 1'b1;
                    in_group_next = 1'b1;
                end
                else
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            status_reg   <= STAT_OK;
            in_group_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            status_reg   <= status_next;
            in_group_reg <= in_group_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    `GAPQ_ASSERT_NXT(a_accept_leaves_idle, (state_reg == ST_IDLE) && s_tvalid,
        (state_reg == ST_EVICT) || (state_reg == ST_RESULT), "accepted item not started")
    `GAPQ_ASSERT_IMP(a_load_slot_free, cmd.load_out, !m_tvalid_reg || m_tready,
        "result overwrites an untaken result")
    `GAPQ_ASSERT_NXT(a_group_marked, (state_reg == ST_EVICT) && drop_ok,
        in_group_reg && (state_reg == ST_EVICT), "eviction drop lost group tracking")

endmodule

### design/gop_aligned_prerecord_queue.sv
`timescale 1ns / 1ps
// Top level of the GOP-aligned prerecord descriptor queue.
// Depends on gapq_pkg, gapq_ctrl and gapq_datapath.
//
//  Channel   Dir  Transaction                       Payload
//  s_*       in   one command (add/peek/pop/clear)  s_tdata, s_tuser
//  m_*       out  one result per command            m_tdata
//  cfg_*     in   register write, no read-back      cfg_addr, cfg_wdata
//
// Peek, pop, clear, refused adds and adds without eviction go through accept and result
// load; an admitted add with eviction goes through accept, the eviction walk and result
// load. The eviction walk removes one descriptor per cycle through the single ring read
// port.
// Reset is asynchronous; ring contents need no clearing, counters reset to empty.
// A finished result waits in the output register; the next command is taken once
// the result has been loaded there.
module gop_aligned_prerecord_queue #(
    parameter int MAX_FRAMES = gapq_pkg::DEF_MAX_FRAMES,
    parameter int LEN_BITS   = gapq_pkg::DEF_LEN_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Command stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // frame_length[23:0], frame_time[86:24], now_time[149:87], allow_evict[150]
    input  logic [gapq_pkg::IN_DATA_W-1:0]      s_tdata,
    // command[1:0], key_frame[2], is_audio[3]
    input  logic [gapq_pkg::IN_USER_W-1:0]      s_tuser,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[2:0], head_valid[3], head_length[27:4], head_time[90:28],
    // head_is_key[91], frame_count[100:92], stored_bytes[132:101],
    // evicted_frames[141:133]
    output logic [gapq_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Register writes
    input  logic                                cfg_we,
    input  logic [gapq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [gapq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import gapq_pkg::*;

    logic [CMD_W-1:0]  command;
    logic [FLEN_W-1:0] frame_length;
    logic [TIME_W-1:0] frame_time;
    logic [TIME_W-1:0] now_time;
    logic              key_frame;
    logic              is_audio;
    logic              allow_evict;
    dp_cmd_t           dp_cmd;
    dp_stat_t          dp_stat;

    // Unpack the command transaction
    assign command      = s_tuser[USER_CMD_LO +: CMD_W];
    assign key_frame    = s_tuser[USER_KEY_BIT];
    assign is_audio     = s_tuser[USER_AUDIO_BIT];
    assign frame_length = s_tdata[IN_LEN_LO +: FLEN_W];
    assign frame_time   = s_tdata[IN_FTIME_LO +: TIME_W];
    assign now_time     = s_tdata[IN_NOW_LO +: TIME_W];
    assign allow_evict  = s_tdata[IN_EVICT_BIT];

    gapq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .command     (command),
        .key_frame   (key_frame),
        .is_audio    (is_audio),
        .allow_evict (allow_evict),
        .stat        (dp_stat),
        .cmd         (dp_cmd)
    );

    gapq_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .LEN_BITS   (LEN_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .frame_length (frame_length),
        .frame_time   (frame_time),
        .key_frame    (key_frame),
        .is_audio     (is_audio),
        .now_time     (now_time),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .out_data     (m_tdata)
    );

endmodule
